>>> design/tgs_pkg.sv
// ----------------------------------------------------------------------------
// tgs_pkg: shared types and constants of the green time splitter
// Field widths, register codes, parameter defaults and register reset values.
// ----------------------------------------------------------------------------
package tgs_pkg;

  localparam int SRC_W      = 2;
  localparam int VCNT_W     = 16;
  localparam int GREEN_W    = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int COUNT_BITS_DEF      = 16;
  localparam int SHARE_FRAC_BITS_DEF = 16;

  localparam logic [7:0]  CYCLE_RST = 8'd120;
  localparam logic [5:0]  LOST_RST  = 6'd4;
  localparam logic [7:0]  MING_RST  = 8'd10;
  localparam logic [15:0] SHARE_RST = 16'd58982;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CYCLE = 2'd0,
    REG_LOST  = 2'd1,
    REG_MING  = 2'd2,
    REG_SHARE = 2'd3
  } reg_idx_t;

  localparam logic [SRC_W-1:0] SRC_NONE = 2'd3;

endpackage

>>> design/tgs_in_if.sv
// ----------------------------------------------------------------------------
// tgs_in_if: count request channel
// Valid/ready channel carrying one tagged vehicle count.
// ----------------------------------------------------------------------------
interface tgs_in_if;
  import tgs_pkg::*;
  logic              valid;
  logic              ready;
  logic [SRC_W-1:0]  source;
  logic [VCNT_W-1:0] vehicle_count;
  modport source_mp (output valid, source, vehicle_count, input ready);
  modport sink (input valid, source, vehicle_count, output ready);
endinterface

>>> design/tgs_out_if.sv
// ----------------------------------------------------------------------------
// tgs_out_if: split result channel
// Valid/ready channel carrying three greens and the counts they came from.
// ----------------------------------------------------------------------------
interface tgs_out_if;
  import tgs_pkg::*;
  logic               valid;
  logic               ready;
  logic [GREEN_W-1:0] green_a;
  logic [GREEN_W-1:0] green_b;
  logic [GREEN_W-1:0] green_c;
  logic [VCNT_W-1:0]  used_count_a;
  logic [VCNT_W-1:0]  used_count_b;
  logic [VCNT_W-1:0]  used_count_c;
  modport source (output valid, green_a, green_b, green_c,
                  used_count_a, used_count_b, used_count_c, input ready);
  modport sink (input valid, green_a, green_b, green_c,
                used_count_a, used_count_b, used_count_c, output ready);
endinterface

>>> design/tgs_cfg_if.sv
// ----------------------------------------------------------------------------
// tgs_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface tgs_cfg_if;
  import tgs_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> design/traffic_green_split.sv
// ----------------------------------------------------------------------------
// traffic_green_split: three approach proportional green time splitter
// Keeps the latest count per approach and splits the green time on request.
// ----------------------------------------------------------------------------
// Usage. in_ch takes one request per count: source 0..2 names approach A..C,
// source 3 updates nothing. in_ready is high only while no split is in
// progress. Once all three kept counts are nonzero a split runs and one
// result goes out on out_ch, after which the kept counts clear. cfg_ch writes
// one register per request and is always ready; write only while idle.
// A split runs on one shift-add multiplier and one restoring divider, each
// quotient followed by a rounding step: three proportional shares, the
// minimum share, up to two reductions and three greens. When the effective
// green (cycle minus three lost times) is not positive, all greens are zero.
// The result sits in an output register; a new request is taken while it
// waits, and a following split holds in its last step until out_ch frees.
// Reset restores the register defaults and clears counts and out_valid.
// ----------------------------------------------------------------------------
module traffic_green_split #(
  parameter int COUNT_BITS      = tgs_pkg::COUNT_BITS_DEF,
  parameter int SHARE_FRAC_BITS = tgs_pkg::SHARE_FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  tgs_in_if.sink    in_ch,
  tgs_out_if.source out_ch,
  tgs_cfg_if.sink   cfg_ch
);
  import tgs_pkg::*;

  localparam int CB    = COUNT_BITS;
  localparam int F     = SHARE_FRAC_BITS;
  localparam int TW    = F + 1;
  localparam int SW    = CB + 2;
  localparam int MW    = F + 9;
  localparam int DFW   = F + 11;
  localparam int YW    = F + 12;
  localparam int NW    = CB + F + 11;
  localparam int DW    = SW;
  localparam int GW    = 22;
  localparam int CNTW  = $clog2(NW + 1);
  localparam int SH_UP = (F >= 16) ? F - 16 : 0;
  localparam int SH_DN = (F < 16) ? 16 - F : 1;
  localparam int TMPW  = TW + 17;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_CHECK = 8'b00000010,
    S_MUL   = 8'b00000100,
    S_DIV   = 8'b00001000,
    S_RND   = 8'b00010000,
    S_ADJ   = 8'b00100000,
    S_GST   = 8'b01000000,
    S_FIN   = 8'b10000000
  } state_t;

  typedef enum logic [3:0] {
    OP_Y = 4'b0001,
    OP_M = 4'b0010,
    OP_R = 4'b0100,
    OP_G = 4'b1000
  } op_t;

  state_t state_r, state_nxt;
  op_t    op_r;
  logic [1:0] i_r;

  logic [7:0]  cycle_r;
  logic [5:0]  lost_r;
  logic [7:0]  ming_r;
  logic [15:0] share_r;

  logic [CB-1:0] cnt_store_r [3];

  logic signed [8:0]    eff_r;
  logic signed [YW-1:0] y_r [3];
  logic signed [GW-1:0] g_r [3];
  logic [MW-1:0]  m_r;
  logic [2:0]     adj_r;
  logic [SW-1:0]  rest_r;
  logic [DFW-1:0] def_r;

  logic [NW-1:0]   a_r, acc_r, q_r;
  logic [CB-1:0]   b_r;
  logic [DW-1:0]   den_r, rem_r;
  logic [CNTW-1:0] cnt_r;

  logic              out_valid_r;
  logic [GREEN_W-1:0] green_r [3];
  logic [VCNT_W-1:0]  used_r [3];

  // Next approach at or after 'from' whose share was not raised; 3 if none.
  function automatic logic [1:0] next_unadj(input logic [2:0] adj, input logic [2:0] from);
    logic [1:0] res;
    res = 2'd3;
    for (int k = 2; k >= 0; k--) begin
      if (!adj[k] && (3'(k) >= from)) res = 2'(k);
    end
    return res;
  endfunction

  function automatic logic [GREEN_W-1:0] sat8(input logic signed [GW-1:0] g);
    if (g < 0) return '0;
    if (g > 255) return 8'd255;
    return g[GREEN_W-1:0];
  endfunction

  // Share total in Q.F.
  logic [TMPW-1:0] tot_tmp;
  logic [TW-1:0]   tot;
  always_comb begin
    if (F >= 16) begin
      tot_tmp = TMPW'(share_r) << SH_UP;
    end else begin
      tot_tmp = (TMPW'(share_r) + (TMPW'(1) << (SH_DN - 1))) >> SH_DN;
    end
    tot = tot_tmp[TW-1:0];
  end

  logic [SW-1:0] sum_c;
  assign sum_c = SW'(cnt_store_r[0]) + SW'(cnt_store_r[1]) + SW'(cnt_store_r[2]);

  logic [7:0] lost3;
  logic signed [8:0] eff_c;
  assign lost3 = 8'(lost_r) * 8'd3;
  assign eff_c = $signed({1'b0, cycle_r}) - $signed({1'b0, lost3});

  // Multiplier step.
  logic [NW-1:0] acc_nxt;
  logic          mul_last;
  assign acc_nxt  = acc_r + (b_r[0] ? a_r : '0);
  assign mul_last = (cnt_r == CNTW'(CB - 1));

  // Green from the finished product (rounding half was preloaded).
  logic [GW-2:0]        gmag;
  logic signed [GW-1:0] gval;
  assign gmag = (GW-1)'(acc_nxt >> F);
  assign gval = y_r[i_r][YW-1] ? -$signed({1'b0, gmag}) : $signed({1'b0, gmag});

  // Divider step.
  logic [DW:0]   div_t;
  logic          div_ge;
  logic [DW-1:0] rem_nxt;
  logic          div_last;
  assign div_t    = {rem_r, q_r[NW-1]};
  assign div_ge   = div_t >= {1'b0, den_r};
  assign rem_nxt  = div_ge ? DW'(div_t - {1'b0, den_r}) : div_t[DW-1:0];
  assign div_last = (cnt_r == CNTW'(NW - 1));

  logic [NW-1:0] rq;
  assign rq = q_r + NW'({rem_r, 1'b0} >= {1'b0, den_r});

  // Minimum share adjustment.
  logic signed [YW-1:0] m_s;
  logic [2:0]     adj_c;
  logic [DFW-1:0] def_c;
  logic [SW-1:0]  rest_c;
  always_comb begin
    m_s    = $signed({{(YW-MW){1'b0}}, m_r});
    def_c  = '0;
    rest_c = '0;
    for (int k = 0; k < 3; k++) begin
      adj_c[k] = y_r[k] < m_s;
      if (adj_c[k]) def_c = def_c + DFW'(m_s - y_r[k]);
      else rest_c = rest_c + SW'(cnt_store_r[k]);
    end
  end

  logic [1:0] first_unadj, next_r_idx;
  assign first_unadj = next_unadj(adj_c, 3'd0);
  assign next_r_idx  = next_unadj(adj_r, 3'(i_r) + 3'd1);

  logic [1:0] i_inc;
  assign i_inc = i_r + 2'd1;

  logic [YW-1:0] ymag_next, ymag0;
  assign ymag_next = y_r[i_inc][YW-1] ? (~y_r[i_inc] + 1'b1) : y_r[i_inc];
  assign ymag0     = y_r[0][YW-1] ? (~y_r[0] + 1'b1) : y_r[0];

  logic [NW-1:0] half;
  assign half = NW'(1) << (F - 1);

  // Final remainder placement.
  logic signed [GW-1:0] rem_g;
  logic [1:0]           k_sel;
  logic signed [GW-1:0] g_fin [3];
  always_comb begin
    rem_g = GW'(eff_r) - (g_r[0] + g_r[1] + g_r[2]);
    if (y_r[0] >= y_r[1] && y_r[0] >= y_r[2]) k_sel = 2'd0;
    else if (y_r[1] >= y_r[2]) k_sel = 2'd1;
    else k_sel = 2'd2;
    for (int k = 0; k < 3; k++) begin
      g_fin[k] = (k_sel == 2'(k)) ? g_r[k] + rem_g : g_r[k];
    end
  end

  logic any_zero;
  assign any_zero = (cnt_store_r[0] == '0) || (cnt_store_r[1] == '0) ||
                    (cnt_store_r[2] == '0);

  logic fin_go;
  assign fin_go = !out_valid_r || out_ch.ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_ch.valid) state_nxt = S_CHECK;
      S_CHECK: begin
        if (any_zero) state_nxt = S_IDLE;
        else if (eff_c <= 0) state_nxt = S_FIN;
        else state_nxt = S_MUL;
      end
      S_MUL: begin
        if (mul_last) begin
          if (op_r != OP_G) state_nxt = S_DIV;
          else if (i_r == 2'd2) state_nxt = S_FIN;
        end
      end
      S_DIV: if (div_last) state_nxt = S_RND;
      S_RND: begin
        case (op_r)
          OP_Y:    state_nxt = (i_r == 2'd2) ? S_DIV : S_MUL;
          OP_M:    state_nxt = S_ADJ;
          OP_R:    state_nxt = (next_r_idx == 2'd3) ? S_GST : S_MUL;
          default: state_nxt = S_IDLE;
        endcase
      end
      S_ADJ: state_nxt = (rest_c != '0 && def_c != '0) ? S_MUL : S_GST;
      S_GST: state_nxt = S_MUL;
      S_FIN: if (fin_go) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= OP_Y;
      i_r         <= '0;
      cycle_r     <= CYCLE_RST;
      lost_r      <= LOST_RST;
      ming_r      <= MING_RST;
      share_r     <= SHARE_RST;
      out_valid_r <= 1'b0;
      for (int k = 0; k < 3; k++) cnt_store_r[k] <= '0;
    end else begin
      state_r <= state_nxt;

      if (cfg_ch.valid) begin
        case (reg_idx_t'(cfg_ch.index))
          REG_CYCLE: cycle_r <= cfg_ch.data[7:0];
          REG_LOST:  lost_r  <= cfg_ch.data[5:0];
          REG_MING:  ming_r  <= cfg_ch.data[7:0];
          REG_SHARE: share_r <= cfg_ch.data;
          default: ;
        endcase
      end

      if (out_valid_r && out_ch.ready) out_valid_r <= 1'b0;

      case (state_r)
        S_IDLE: begin
          if (in_ch.valid && in_ch.source != SRC_NONE) begin
            cnt_store_r[in_ch.source] <= CB'(in_ch.vehicle_count);
          end
        end
        S_CHECK: begin
          eff_r <= eff_c;
          for (int k = 0; k < 3; k++) begin
            g_r[k] <= '0;
            y_r[k] <= '0;
          end
          op_r  <= OP_Y;
          i_r   <= 2'd0;
          a_r   <= NW'(tot);
          b_r   <= cnt_store_r[0];
          acc_r <= '0;
          cnt_r <= '0;
        end
        S_MUL: begin
          acc_r <= acc_nxt;
          a_r   <= a_r << 1;
          b_r   <= b_r >> 1;
          cnt_r <= cnt_r + 1'b1;
          if (mul_last) begin
            cnt_r <= '0;
            if (op_r == OP_G) begin
              g_r[i_r] <= gval;
              if (i_r != 2'd2) begin
                i_r   <= i_inc;
                a_r   <= NW'(ymag_next);
                b_r   <= CB'(eff_r[7:0]);
                acc_r <= half;
              end
            end else begin
              q_r   <= acc_nxt;
              rem_r <= '0;
              den_r <= (op_r == OP_Y) ? sum_c : rest_r;
            end
          end
        end
        S_DIV: begin
          q_r   <= {q_r[NW-2:0], div_ge};
          rem_r <= rem_nxt;
          cnt_r <= cnt_r + 1'b1;
        end
        S_RND: begin
          cnt_r <= '0;
          acc_r <= '0;
          case (op_r)
            OP_Y: begin
              y_r[i_r] <= $signed({1'b0, rq[YW-2:0]});
              if (i_r == 2'd2) begin
                op_r  <= OP_M;
                q_r   <= NW'({ming_r, {F{1'b0}}});
                rem_r <= '0;
                den_r <= DW'(eff_r[7:0]);
              end else begin
                i_r <= i_inc;
                a_r <= NW'(tot);
                b_r <= cnt_store_r[i_inc];
              end
            end
            OP_M: m_r <= rq[MW-1:0];
            OP_R: begin
              y_r[i_r] <= y_r[i_r] - $signed({1'b0, rq[YW-2:0]});
              if (next_r_idx != 2'd3) begin
                i_r <= next_r_idx;
                a_r <= NW'(def_r);
                b_r <= cnt_store_r[next_r_idx];
              end
            end
            default: ;
          endcase
        end
        S_ADJ: begin
          adj_r  <= adj_c;
          rest_r <= rest_c;
          def_r  <= def_c;
          for (int k = 0; k < 3; k++) begin
            if (adj_c[k]) y_r[k] <= m_s;
          end
          op_r  <= OP_R;
          i_r   <= first_unadj;
          a_r   <= NW'(def_c);
          b_r   <= cnt_store_r[first_unadj];
          acc_r <= '0;
          cnt_r <= '0;
        end
        S_GST: begin
          op_r  <= OP_G;
          i_r   <= 2'd0;
          a_r   <= NW'(ymag0);
          b_r   <= CB'(eff_r[7:0]);
          acc_r <= half;
          cnt_r <= '0;
        end
        S_FIN: begin
          if (fin_go) begin
            out_valid_r <= 1'b1;
            for (int k = 0; k < 3; k++) begin
              green_r[k]     <= sat8(g_fin[k]);
              used_r[k]      <= VCNT_W'(cnt_store_r[k]);
              cnt_store_r[k] <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.green_a      = green_r[0];
  assign out_ch.green_b      = green_r[1];
  assign out_ch.green_c      = green_r[2];
  assign out_ch.used_count_a = used_r[0];
  assign out_ch.used_count_b = used_r[1];
  assign out_ch.used_count_c = used_r[2];

endmodule

>>> dv/tb_traffic_green_split.sv
// ----------------------------------------------------------------------------
// tb_traffic_green_split: self-checking bench of the green time splitter
// Drives tagged counts and register writes with random idling, predicts each
// split in integer arithmetic and compares every accepted result in all fields.
// ----------------------------------------------------------------------------
module tb_traffic_green_split;
  import tgs_pkg::*;

  typedef struct packed {
    logic [SRC_W-1:0]  source;
    logic [VCNT_W-1:0] vehicle_count;
  } count_req_t;

  typedef struct packed {
    logic [7:0]  green_a;
    logic [7:0]  green_b;
    logic [7:0]  green_c;
    logic [15:0] used_a;
    logic [15:0] used_b;
    logic [15:0] used_c;
  } split_t;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 600;

  logic clk;
  logic rst_n;

  tgs_in_if  in_ch ();
  tgs_out_if out_ch ();
  tgs_cfg_if cfg_ch ();

  traffic_green_split i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source),
    .cfg_ch(cfg_ch.sink)
  );

  count_req_t pending_reqs[$];
  split_t     expected_splits[$];

  // Model copy of the registers and kept counts.
  logic [7:0]  m_cycle;
  logic [5:0]  m_lost;
  logic [7:0]  m_ming;
  logic [15:0] m_share;
  logic [15:0] m_count[3];

  int  mismatches;
  int  splits_seen;
  int  reqs_sent;
  int  idle_cycles;
  bit  no_idle;
  bit  in_fired;
  bit  hold_off_req;
  int  hold_off_left;
  int  in_gap;
  int  out_gap;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic longint div_round_up(longint num, longint den);
    return (2 * num + den) / (2 * den);
  endfunction

  function automatic longint round_away16(longint n);
    if (n >= 0) return (n + 32768) >>> 16;
    return -((-n + 32768) >>> 16);
  endfunction

  // Proportional split with minimum raise, reduction and remainder.
  function automatic split_t green_split();
    split_t r;
    longint eff, tot, sum, rest, m, def, rem;
    longint y[3];
    longint g[3];
    bit     raised[3];
    int     k;
    eff  = longint'(m_cycle) - 3 * longint'(m_lost);
    rest = 0;
    def  = 0;
    if (eff <= 0) begin
      g[0] = 0; g[1] = 0; g[2] = 0;
    end else begin
      tot = longint'(m_share);
      sum = longint'(m_count[0]) + longint'(m_count[1]) + longint'(m_count[2]);
      for (int i = 0; i < 3; i++) y[i] = div_round_up(longint'(m_count[i]) * tot, sum);
      m = div_round_up(longint'(m_ming) * 65536, eff);
      for (int i = 0; i < 3; i++) begin
        raised[i] = y[i] < m;
        if (raised[i]) begin
          def += m - y[i];
          y[i] = m;
        end else begin
          rest += longint'(m_count[i]);
        end
      end
      if (rest > 0 && def > 0)
        for (int i = 0; i < 3; i++)
          if (!raised[i]) y[i] -= div_round_up(def * longint'(m_count[i]), rest);
      for (int i = 0; i < 3; i++) g[i] = round_away16(y[i] * eff);
      rem = eff - (g[0] + g[1] + g[2]);
      if (y[0] >= y[1] && y[0] >= y[2]) k = 0;
      else if (y[1] >= y[2]) k = 1;
      else k = 2;
      g[k] += rem;
      for (int i = 0; i < 3; i++) begin
        if (g[i] < 0) g[i] = 0;
        if (g[i] > 255) g[i] = 255;
      end
    end
    r.green_a = g[0][7:0];
    r.green_b = g[1][7:0];
    r.green_c = g[2][7:0];
    r.used_a  = m_count[0];
    r.used_b  = m_count[1];
    r.used_c  = m_count[2];
    return r;
  endfunction

  task automatic predict_count(count_req_t q);
    if (q.source != SRC_NONE) m_count[q.source] = q.vehicle_count;
    if (m_count[0] != 0 && m_count[1] != 0 && m_count[2] != 0) begin
      expected_splits.push_back(green_split());
      m_count[0] = 0; m_count[1] = 0; m_count[2] = 0;
    end
  endtask

  // Driver: offers requests from the queue, with random gaps.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && !in_fired) begin
      // hold the request until it is taken
    end else if (in_gap > 0) begin
      in_gap      <= in_gap - 1;
      in_ch.valid <= 1'b0;
    end else if (pending_reqs.size() > 0) begin
      in_ch.valid         <= 1'b1;
      in_ch.source        <= pending_reqs[0].source;
      in_ch.vehicle_count <= pending_reqs[0].vehicle_count;
      if (!no_idle && $urandom_range(0, 7) == 0) in_gap <= $urandom_range(1, 6);
    end else begin
      in_ch.valid <= 1'b0;
    end
  end

  // Receiver ready with bursts of stall and an optional long hold-off.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_off_left > 0) begin
      hold_off_left <= hold_off_left - 1;
      out_ch.ready  <= 1'b0;
    end else if (hold_off_req) begin
      hold_off_req  <= 1'b0;
      hold_off_left <= 3000;
      out_ch.ready  <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap      <= out_gap - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      if (!no_idle && $urandom_range(0, 5) == 0) out_gap <= $urandom_range(1, 6);
    end
  end

  // Monitor: predicts on accepted requests and checks accepted results.
  always @(posedge clk) begin
    split_t act, exp_r;
    if (rst_n) begin
      idle_cycles <= idle_cycles + 1;
      in_fired    <= in_ch.valid && in_ch.ready;
      if (in_ch.valid && in_ch.ready) begin
        predict_count(pending_reqs.pop_front());
        reqs_sent   <= reqs_sent + 1;
        idle_cycles <= 0;
      end
      if (out_ch.valid && out_ch.ready) begin
        idle_cycles <= 0;
        splits_seen <= splits_seen + 1;
        act = '{out_ch.green_a, out_ch.green_b, out_ch.green_c,
                out_ch.used_count_a, out_ch.used_count_b, out_ch.used_count_c};
        if (expected_splits.size() == 0) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10) $display("unexpected result %p", act);
        end else begin
          exp_r = expected_splits.pop_front();
          if (act !== exp_r) begin
            mismatches = mismatches + 1;
            if (mismatches <= 10) $display("mismatch: expected %p actual %p", exp_r, act);
          end
        end
      end
      if (idle_cycles > WATCHDOG_LIMIT) begin
        $display("watchdog expired");
        $display("FAIL traffic_green_split");
        $finish;
      end
    end
  end

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || expected_splits.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [15:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      REG_CYCLE: m_cycle = val[7:0];
      REG_LOST:  m_lost  = val[5:0];
      REG_MING:  m_ming  = val[7:0];
      REG_SHARE: m_share = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic push_count(logic [1:0] src, logic [15:0] cnt);
    pending_reqs.push_back('{src, cnt});
  endtask

  // Mostly complete triples with random content, plus noise.
  task automatic push_random(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 4) != 0) begin
        push_count(2'd0, $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(1, 300)));
        push_count(2'd1, $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(1, 300)));
        push_count(2'd2, $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(1, 300)));
        i += 2;
      end else begin
        push_count(2'($urandom_range(0, 3)), $urandom_range(0, 1) ? 16'($urandom) : 16'd0);
      end
    end
  endtask

  task automatic random_cfg();
    write_reg(REG_CYCLE, 16'($urandom_range(1, 255)));
    write_reg(REG_LOST, 16'($urandom_range(0, 63)));
    write_reg(REG_MING, 16'($urandom_range(0, 255)));
    write_reg(REG_SHARE, 16'($urandom));
  endtask

  initial begin
    mismatches = 0; splits_seen = 0; reqs_sent = 0; idle_cycles = 0;
    no_idle = 0; in_fired = 0; hold_off_req = 0; hold_off_left = 0;
    in_gap = 0; out_gap = 0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0; in_ch.source = '0; in_ch.vehicle_count = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0; cfg_ch.index = REG_CYCLE; cfg_ch.data = '0;
    m_cycle = CYCLE_RST; m_lost = LOST_RST; m_ming = MING_RST; m_share = SHARE_RST;
    m_count[0] = 0; m_count[1] = 0; m_count[2] = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: extremes, unrecognized sender, zeros, two raised shares.
    push_count(2'd0, 16'hFFFF); push_count(2'd1, 16'hFFFF); push_count(2'd2, 16'hFFFF);
    push_count(2'd0, 16'd1); push_count(2'd1, 16'd1); push_count(2'd2, 16'hFFFF);
    push_count(2'd0, 16'd5); push_count(2'd1, 16'd0); push_count(2'd2, 16'd7);
    push_count(2'd1, 16'd9); push_count(SRC_NONE, 16'hAAAA);
    push_count(2'd0, 16'd3); push_count(2'd1, 16'd3); push_count(SRC_NONE, 16'h5555);
    push_count(2'd2, 16'd3);
    wait_drained();

    // Every input shows both values; long receiver hold-off fills the block.
    hold_off_req = 1;
    push_random(60);
    wait_drained();

    // Extreme settings: no effective time, huge minimum, zero share total.
    write_reg(REG_CYCLE, 16'd9); write_reg(REG_LOST, 16'd63);
    push_count(2'd0, 16'd4); push_count(2'd1, 16'd5); push_count(2'd2, 16'd6);
    wait_drained();
    write_reg(REG_CYCLE, 16'd255); write_reg(REG_LOST, 16'd0);
    write_reg(REG_MING, 16'd255); write_reg(REG_SHARE, 16'hFFFF);
    push_count(2'd0, 16'd1); push_count(2'd1, 16'd100); push_count(2'd2, 16'd65535);
    wait_drained();
    write_reg(REG_CYCLE, 16'd1); write_reg(REG_MING, 16'd0); write_reg(REG_SHARE, 16'd0);
    push_count(2'd0, 16'd2); push_count(2'd1, 16'd1); push_count(2'd2, 16'd1);
    push_random(30);
    wait_drained();

    for (int p = 0; p < 7; p++) begin
      random_cfg();
      push_random(110);
      wait_drained();
    end

    write_reg(REG_CYCLE, 16'd120); write_reg(REG_LOST, 16'd4);
    write_reg(REG_MING, 16'd10); write_reg(REG_SHARE, 16'd58982);
    no_idle = 1;
    push_random(80);
    wait_drained();

    $display("Sent %0d count requests over twelve register settings; checked %0d splits.",
             reqs_sent, splits_seen);
    if (mismatches == 0) begin
      $display("PASS traffic_green_split");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("FAIL traffic_green_split");
    end
    $finish;
  end

endmodule
